// ===== sv/ttfe_pkg.sv =====
// Shared types, widths and helpers for the two-tap feedback echo.
// No dependencies; every other file of the block imports this package.
package ttfe_pkg;

    localparam int SAMPLE_W = 16;
    localparam int DELAY_W  = 15;
    localparam int GAIN_W   = 16;
    localparam int COEF_W   = 16;
    localparam int MUL_W    = 17;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int ACC_W    = PROD_W;
    localparam int Y_SHIFT  = 14;
    localparam int W_SHIFT  = 15;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FIRST_DELAY  = 3'd0,
        CFG_SECOND_DELAY = 3'd1,
        CFG_GAIN         = 3'd2,
        CFG_B0           = 3'd3,
        CFG_B1           = 3'd4,
        CFG_B2           = 3'd5,
        CFG_A1           = 3'd6,
        CFG_A2           = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic mul_en;
        logic acc_load;
        logic acc_add;
    } t_mac_ctl;

    function automatic logic signed [ACC_W-1:0] f_sext16(input logic signed [SAMPLE_W-1:0] v);
        return {{(ACC_W-SAMPLE_W){v[SAMPLE_W-1]}}, v};
    endfunction

    // Saturate a wide signed value to the 16-bit sample range.
    function automatic logic signed [SAMPLE_W-1:0] f_sat16(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-SAMPLE_W:0] top_bits;
        top_bits = v[ACC_W-1:SAMPLE_W-1];
        if ((&top_bits) || !(|top_bits)) begin
            return v[SAMPLE_W-1:0];
        end else if (v[ACC_W-1]) begin
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        end else begin
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
        end
    endfunction

endpackage

// ===== sv/ttfe_delay_ram.sv =====
// Delay line storage: one write port and one read port with registered data.
// Depends on ttfe_pkg for the sample width.
module ttfe_delay_ram #(
    parameter int DEPTH = 32768
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [$clog2(DEPTH)-1:0]                i_waddr,
    input  logic signed [ttfe_pkg::SAMPLE_W-1:0]    i_wdata,
    input  logic [$clog2(DEPTH)-1:0]                i_raddr,
    output logic signed [ttfe_pkg::SAMPLE_W-1:0]    o_rdata
);
    import ttfe_pkg::*;

    logic signed [SAMPLE_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== sv/ttfe_delay_mod.sv =====
// Holds both tap delays, each reduced modulo the line depth by a reciprocal
// multiplication in the cycle after it is written. Depends on ttfe_pkg.
module ttfe_delay_mod #(
    parameter int DEPTH = 32768
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic                              i_sel,
    input  logic [ttfe_pkg::DELAY_W-1:0]      i_value,
    output logic                              o_busy,
    output logic [$clog2(DEPTH)-1:0]          o_delay1,
    output logic [$clog2(DEPTH)-1:0]          o_delay2
);
    import ttfe_pkg::*;

    localparam int AW      = $clog2(DEPTH);
    localparam int REC_W   = DELAY_W + 2;
    localparam int PROD_DW = DELAY_W + REC_W;
    localparam int SHIFT   = DELAY_W + AW;
    // Rounded-up reciprocal of the depth; with this shift the quotient is exact
    // for every delay that fits in the delay field.
    localparam longint RECIP_L =
        ((longint'(1) << SHIFT) + longint'(DEPTH) - 1) / longint'(DEPTH);
    localparam logic [REC_W-1:0]   RECIP    = REC_W'(RECIP_L);
    localparam logic [DELAY_W-1:0] DEPTH_LO = DELAY_W'(DEPTH);

    typedef enum logic {RS_IDLE, RS_RUN} t_rstate;

    t_rstate              r_state;
    logic [DELAY_W-1:0]   r_val;
    logic [PROD_DW-1:0]   r_prod;
    logic                 r_sel;
    logic [DELAY_W-1:0]   quo;
    logic [DELAY_W-1:0]   rem;

    // The remainder is smaller than the depth and no larger than the delay, so it fits the delay width.
    assign quo = DELAY_W'(r_prod >> SHIFT);
    assign rem = r_val - quo * DEPTH_LO;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= RS_IDLE;
            o_delay1 <= AW'(1);
            o_delay2 <= AW'(1);
        end else begin
            case (r_state)
                RS_IDLE: begin
                    if (i_start) begin
                        r_val   <= i_value;
                        r_prod  <= i_value * RECIP;
                        r_sel   <= i_sel;
                        r_state <= RS_RUN;
                    end
                end
                RS_RUN: begin
                    if (r_sel) begin
                        o_delay2 <= AW'(rem);
                    end else begin
                        o_delay1 <= AW'(rem);
                    end
                    r_state <= RS_IDLE;
                end
                default: r_state <= RS_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state == RS_RUN);

endmodule

// ===== sv/ttfe_mac.sv =====
// Shared 17x17 signed multiplier with a registered product and accumulator,
// plus the rounding and saturation of filter and feedback outputs. Uses ttfe_pkg.
module ttfe_mac (
    input  logic                                  i_clk,
    input  ttfe_pkg::t_mac_ctl                    i_ctl,
    input  logic signed [ttfe_pkg::MUL_W-1:0]     i_op_a,
    input  logic signed [ttfe_pkg::MUL_W-1:0]     i_op_b,
    output logic signed [ttfe_pkg::SAMPLE_W-1:0]  o_y,
    output logic signed [ttfe_pkg::SAMPLE_W-1:0]  o_w
);
    import ttfe_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  y_round;
    logic signed [ACC_W-1:0]  w_round;

    always_ff @(posedge i_clk) begin
        if (i_ctl.mul_en) begin
            r_prod <= i_op_a * i_op_b;
        end
        if (i_ctl.acc_load) begin
            r_acc <= r_prod;
        end else if (i_ctl.acc_add) begin
            r_acc <= r_acc + r_prod;
        end
    end

    // Round half up, then floor-shift back to sample scale.
    assign y_round = (r_acc + ACC_W'(1 << (Y_SHIFT - 1))) >>> Y_SHIFT;
    assign w_round = (r_prod + PROD_W'(1 << (W_SHIFT - 1))) >>> W_SHIFT;
    assign o_y     = f_sat16(y_round);
    assign o_w     = f_sat16(w_round);

endmodule

// ===== sv/two_tap_feedback_echo.sv =====
// Two-tap feedback echo: circular delay line, biquad damping filter, feedback.
// An item's passage is set by six products through the one shared multiplier
// and two reads through one RAM port; it waits while the previous result is held.
// Reset clears the filter history and write position, then sweeps every word
// of the line writing zeros; items are stalled until the sweep ends.
// A tap delay write holds the configuration port while the delay is reduced.
module two_tap_feedback_echo #(
    parameter int DELAY_DEPTH = 32768
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_stall,
    input  logic signed [ttfe_pkg::SAMPLE_W-1:0]    i_sample,
    output logic                                    o_out_valid,
    input  logic                                    i_out_stall,
    output logic signed [ttfe_pkg::SAMPLE_W-1:0]    o_first_tap,
    output logic signed [ttfe_pkg::SAMPLE_W-1:0]    o_second_tap,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [ttfe_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [ttfe_pkg::CFG_DATA_W-1:0]         i_cfg_data
);
    import ttfe_pkg::*;

    localparam int AW = $clog2(DELAY_DEPTH);

    // The sequencer walks the item through the shared multiplier: the first two
    // history products are started while the two taps are being read, the other
    // two after, then the input product, the rounding of the filter output and the gain.
    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_RD2, ST_SUM, ST_M3, ST_M4, ST_ACC, ST_Y, ST_G, ST_WR
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [GAIN_W-1:0]        r_gain;
    logic signed [COEF_W-1:0] r_b0, r_b1, r_b2, r_a1, r_a2;

    // Filter history and item working registers.
    logic signed [SAMPLE_W-1:0] r_x0, r_x1, r_y0, r_y1;
    logic signed [SAMPLE_W-1:0] r_sample, r_t1, r_t2, r_sum, r_y;
    logic [AW-1:0]              r_wp;
    logic [AW-1:0]              r_clr_addr;

    logic [AW-1:0]              delay1, delay2;
    logic                       dm_busy;
    logic                       dm_start;
    logic                       cfg_write;
    logic                       in_accept;
    logic                       out_free;
    logic                       wr_done;
    logic [AW-1:0]              wp_inc;
    logic [AW-1:0]              tap1_addr, tap2_addr;
    logic [AW:0]                diff1, diff2;
    logic [AW-1:0]              ram_raddr, ram_waddr;
    logic                       ram_we;
    logic signed [SAMPLE_W-1:0] ram_wdata, ram_rdata;
    t_mac_ctl                   mac_ctl;
    logic signed [MUL_W-1:0]    op_a, op_b;
    logic signed [SAMPLE_W-1:0] mac_y, mac_w;
    logic signed [SAMPLE_W-1:0] tap_sum;

    assign cfg_write = i_cfg_valid && o_cfg_ready;
    assign o_cfg_ready = !dm_busy;
    assign dm_start = cfg_write && ((t_cfg_reg'(i_cfg_index) == CFG_FIRST_DELAY) ||
                                    (t_cfg_reg'(i_cfg_index) == CFG_SECOND_DELAY));

    ttfe_delay_mod #(.DEPTH(DELAY_DEPTH)) u_delay_mod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (dm_start),
        .i_sel    (t_cfg_reg'(i_cfg_index) == CFG_SECOND_DELAY),
        .i_value  (i_cfg_data[DELAY_W-1:0]),
        .o_busy   (dm_busy),
        .o_delay1 (delay1),
        .o_delay2 (delay2)
    );

    // Tap address: write position minus the reduced delay, wrapped once.
    // A zero delay lands on the write position itself, read before the write.
    assign diff1 = {1'b0, r_wp} - {1'b0, delay1};
    assign diff2 = {1'b0, r_wp} - {1'b0, delay2};
    assign tap1_addr = diff1[AW] ? AW'(diff1 + (AW+1)'(DELAY_DEPTH)) : diff1[AW-1:0];
    assign tap2_addr = diff2[AW] ? AW'(diff2 + (AW+1)'(DELAY_DEPTH)) : diff2[AW-1:0];
    assign wp_inc = (r_wp == AW'(DELAY_DEPTH - 1)) ? '0 : r_wp + 1'b1;

    assign o_in_stall = (r_state != ST_IDLE);
    assign in_accept  = i_in_valid && !o_in_stall;
    assign out_free   = !o_out_valid || !i_out_stall;
    assign wr_done    = (r_state == ST_WR) && out_free;

    // The RAM reads the first tap in the accepting cycle and the second after.
    assign ram_raddr = (r_state == ST_RD2) ? tap2_addr : tap1_addr;
    assign ram_we    = (r_state == ST_CLEAR) || wr_done;
    assign ram_waddr = (r_state == ST_CLEAR) ? r_clr_addr : r_wp;
    assign ram_wdata = (r_state == ST_CLEAR) ? '0 : mac_w;

    ttfe_delay_ram #(.DEPTH(DELAY_DEPTH)) u_delay_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign tap_sum = f_sat16(f_sext16(ram_rdata) + f_sext16(r_sample));

    // Operand selection for the shared multiplier. The feedback coefficients
    // are negated here so that the accumulator only ever adds.
    always_comb begin
        mac_ctl = '0;
        op_a    = '0;
        op_b    = '0;
        case (r_state)
            ST_IDLE: begin
                mac_ctl.mul_en = in_accept;
                op_a = {r_b1[COEF_W-1], r_b1};
                op_b = {r_x0[SAMPLE_W-1], r_x0};
            end
            ST_RD2: begin
                mac_ctl.mul_en   = 1'b1;
                mac_ctl.acc_load = 1'b1;
                op_a = {r_b2[COEF_W-1], r_b2};
                op_b = {r_x1[SAMPLE_W-1], r_x1};
            end
            ST_SUM: begin
                mac_ctl.mul_en  = 1'b1;
                mac_ctl.acc_add = 1'b1;
                op_a = -{r_a1[COEF_W-1], r_a1};
                op_b = {r_y0[SAMPLE_W-1], r_y0};
            end
            ST_M3: begin
                mac_ctl.mul_en  = 1'b1;
                mac_ctl.acc_add = 1'b1;
                op_a = -{r_a2[COEF_W-1], r_a2};
                op_b = {r_y1[SAMPLE_W-1], r_y1};
            end
            ST_M4: begin
                mac_ctl.mul_en  = 1'b1;
                mac_ctl.acc_add = 1'b1;
                op_a = {r_b0[COEF_W-1], r_b0};
                op_b = {r_sum[SAMPLE_W-1], r_sum};
            end
            ST_ACC: begin
                mac_ctl.acc_add = 1'b1;
            end
            ST_G: begin
                mac_ctl.mul_en = 1'b1;
                op_a = {r_y[SAMPLE_W-1], r_y};
                op_b = {1'b0, r_gain};
            end
            default: begin
                mac_ctl = '0;
            end
        endcase
    end

    ttfe_mac u_mac (
        .i_clk  (i_clk),
        .i_ctl  (mac_ctl),
        .i_op_a (op_a),
        .i_op_b (op_b),
        .o_y    (mac_y),
        .o_w    (mac_w)
    );

    // Sequencer, configuration registers, filter history and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_wp        <= '0;
            r_x0        <= '0;
            r_x1        <= '0;
            r_y0        <= '0;
            r_y1        <= '0;
            r_gain      <= '0;
            r_b0        <= COEF_W'(16384);
            r_b1        <= '0;
            r_b2        <= '0;
            r_a1        <= '0;
            r_a2        <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (cfg_write) begin
                case (t_cfg_reg'(i_cfg_index))
                    CFG_GAIN: r_gain <= i_cfg_data[GAIN_W-1:0];
                    CFG_B0:   r_b0   <= i_cfg_data[COEF_W-1:0];
                    CFG_B1:   r_b1   <= i_cfg_data[COEF_W-1:0];
                    CFG_B2:   r_b2   <= i_cfg_data[COEF_W-1:0];
                    CFG_A1:   r_a1   <= i_cfg_data[COEF_W-1:0];
                    CFG_A2:   r_a2   <= i_cfg_data[COEF_W-1:0];
                    default: begin
                        // Tap delays are held by the reduction unit.
                    end
                endcase
            end

            // A finished item loads a new result; otherwise a taken result
            // empties the output register.
            if (wr_done) begin
                o_out_valid <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                o_out_valid <= 1'b0;
            end

            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == AW'(DELAY_DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (in_accept) begin
                        r_sample <= i_sample;
                        r_state  <= ST_RD2;
                    end
                end
                ST_RD2: begin
                    r_t1    <= ram_rdata;
                    r_state <= ST_SUM;
                end
                ST_SUM: begin
                    r_t2    <= ram_rdata;
                    r_sum   <= tap_sum;
                    r_state <= ST_M3;
                end
                ST_M3:  r_state <= ST_M4;
                ST_M4:  r_state <= ST_ACC;
                ST_ACC: r_state <= ST_Y;
                ST_Y: begin
                    r_y     <= mac_y;
                    r_state <= ST_G;
                end
                ST_G: r_state <= ST_WR;
                ST_WR: begin
                    // Waits here while the previous result is still held.
                    if (out_free) begin
                        r_x1         <= r_x0;
                        r_x0         <= r_sum;
                        r_y1         <= r_y0;
                        r_y0         <= r_y;
                        r_wp         <= wp_inc;
                        o_first_tap  <= r_t1;
                        o_second_tap <= r_t2;
                        r_state      <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // The write position never leaves the line.
    a_wp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wp <= AW'(DELAY_DEPTH - 1))
        else $error("write position beyond delay line depth");

    // A completed item always leaves a result in the output register.
    a_wr_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_done |=> o_out_valid)
        else $error("completed item left no result");

    // A new result only appears from the write state.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == ST_WR)
        else $error("result raised outside the write state");

    // The write position advances by exactly one for each completed item.
    a_wp_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_done |=> r_wp == $past(wp_inc))
        else $error("write position did not advance by one");

endmodule

// ===== sim/tb.sv =====
// Self-checking bench for two_tap_feedback_echo: directed and random sample streams
// are checked against a bit-exact predictor of the echo line and damping filter.
// Depends on ttfe_pkg and the two_tap_feedback_echo RTL.
`timescale 1ns / 1ps

module tb;
    import ttfe_pkg::*;

    localparam int LINE_DEPTH     = 1 << DELAY_W;
    // The clearing pass after reset is the longest legitimate stretch without a
    // handshake, so the watchdog allows several times that.
    localparam int WATCHDOG_LIMIT = 4 * LINE_DEPTH;
    localparam int ITEMS_PER_RUN  = 255;
    localparam int SETTLE_CYCLES  = 20;

    typedef enum int {TUNE_GENTLE, TUNE_WILD, TUNE_EXTREME} t_tune;

    typedef struct {
        logic signed [SAMPLE_W-1:0] first_tap;
        logic signed [SAMPLE_W-1:0] second_tap;
    } t_tap_pair;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic signed [SAMPLE_W-1:0]  i_sample;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic signed [SAMPLE_W-1:0]  o_first_tap;
    logic signed [SAMPLE_W-1:0]  o_second_tap;
    logic                        i_cfg_valid;
    logic                        o_cfg_ready;
    logic [CFG_IDX_W-1:0]        i_cfg_index;
    logic [CFG_DATA_W-1:0]       i_cfg_data;

    // Predictor state: a private copy of the delay line, write pointer, filter
    // history and the register settings as last written.
    logic signed [SAMPLE_W-1:0]  echo_line [LINE_DEPTH];
    logic [DELAY_W-1:0]          line_pos;
    logic signed [SAMPLE_W-1:0]  mix_hist [2];
    logic signed [SAMPLE_W-1:0]  wet_hist [2];
    logic [DELAY_W-1:0]          tap1_delay;
    logic [DELAY_W-1:0]          tap2_delay;
    logic [GAIN_W-1:0]           fb_gain;
    logic signed [COEF_W-1:0]    coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;

    logic signed [SAMPLE_W-1:0]  pending_samples [$];
    t_tap_pair                   tap_pairs_due [$];
    bit                          in_busy;
    int                          sender_gap;
    int                          sink_gap;
    int                          sender_odds;
    int                          sink_odds;
    int                          quiet_cycles;
    int                          fault_count;

    two_tap_feedback_echo #(
        .DELAY_DEPTH (LINE_DEPTH)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_sample     (i_sample),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_first_tap  (o_first_tap),
        .o_second_tap (o_second_tap),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic signed [SAMPLE_W-1:0] clip16(longint v);
        if (v > 32767) begin
            return 16'sh7fff;
        end
        if (v < -32768) begin
            return 16'sh8000;
        end
        return v[SAMPLE_W-1:0];
    endfunction

    // One sample through the echo: read both taps before the write, feed the
    // second tap plus the dry sample through the biquad, scale by the feedback
    // gain and write the result at the current pointer. The pointer is 15 bits
    // wide, so the tap address wraps on its own; a delay of zero therefore
    // reads the word that is about to be overwritten.
    function automatic t_tap_pair echo_step(logic signed [SAMPLE_W-1:0] dry);
        t_tap_pair                  taps;
        logic signed [SAMPLE_W-1:0] mix;
        logic signed [SAMPLE_W-1:0] wet;
        longint                     acc;
        taps.first_tap  = echo_line[DELAY_W'(line_pos - tap1_delay)];
        taps.second_tap = echo_line[DELAY_W'(line_pos - tap2_delay)];
        mix = clip16(longint'(taps.second_tap) + longint'(dry));
        acc = longint'(coef_b0) * mix
            + longint'(coef_b1) * mix_hist[0]
            + longint'(coef_b2) * mix_hist[1]
            - longint'(coef_a1) * wet_hist[0]
            - longint'(coef_a2) * wet_hist[1];
        // Round half up, then floor by arithmetic shift.
        wet = clip16((acc + (longint'(1) <<< (Y_SHIFT - 1))) >>> Y_SHIFT);
        mix_hist[1] = mix_hist[0];
        mix_hist[0] = mix;
        wet_hist[1] = wet_hist[0];
        wet_hist[0] = wet;
        echo_line[line_pos] = clip16((longint'(wet) * longint'(fb_gain)
                                      + (longint'(1) <<< (W_SHIFT - 1))) >>> W_SHIFT);
        line_pos = line_pos + 1'b1;
        return taps;
    endfunction

    // Sample driver: presents the next queued sample at the falling edge and
    // holds it until the request is taken. Idle bursts only start between
    // requests, and the data lines carry noise whenever valid is low.
    always @(negedge i_clk) begin : sample_driver
        logic                       go;
        logic signed [SAMPLE_W-1:0] next_sample;
        go = 1'b0;
        next_sample = SAMPLE_W'($urandom);
        if (!in_busy) begin
            if (sender_gap != 0) begin
                sender_gap = sender_gap - 1;
            end else if ($urandom_range(99) < sender_odds) begin
                sender_gap = $urandom_range(7, 0);
            end else if (pending_samples.size() != 0) begin
                go = 1'b1;
                next_sample = pending_samples.pop_front();
                in_busy = 1'b1;
            end
            i_in_valid <= go;
            i_sample   <= next_sample;
        end
    end

    // Receiver stall, in random bursts.
    always @(negedge i_clk) begin : sink_stall
        if (sink_gap != 0) begin
            sink_gap = sink_gap - 1;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(99) < sink_odds) begin
            sink_gap = $urandom_range(7, 0);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Monitor: checks each delivered result against the oldest prediction,
    // then records an accepted sample. Doing both in one block keeps the order
    // of the queue operations fixed.
    always @(posedge i_clk) begin : tap_monitor
        t_tap_pair due;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (tap_pairs_due.size() == 0) begin
                    $error("result with no request outstanding: first_tap %0d, second_tap %0d",
                           o_first_tap, o_second_tap);
                    fault_count++;
                end else begin
                    due = tap_pairs_due.pop_front();
                    if (o_first_tap !== due.first_tap) begin
                        $error("first_tap: expected %0d, actual %0d", due.first_tap, o_first_tap);
                        fault_count++;
                    end
                    if (o_second_tap !== due.second_tap) begin
                        $error("second_tap: expected %0d, actual %0d", due.second_tap, o_second_tap);
                        fault_count++;
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                tap_pairs_due.push_back(echo_step(i_sample));
                in_busy = 1'b0;
            end
        end
    end

    // Watchdog: a long stretch without any handshake on any channel means the
    // block has hung.
    always @(posedge i_clk) begin : watchdog
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("two_tap_feedback_echo verification failed");
            $finish;
        end
    end

    // Writes one register and mirrors it into the predictor once the request
    // has been taken. Tap delays keep only their low fifteen bits.
    task automatic write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            CFG_FIRST_DELAY:  tap1_delay = val[DELAY_W-1:0];
            CFG_SECOND_DELAY: tap2_delay = val[DELAY_W-1:0];
            CFG_GAIN:         fb_gain    = val;
            CFG_B0:           coef_b0    = val;
            CFG_B1:           coef_b1    = val;
            CFG_B2:           coef_b2    = val;
            CFG_A1:           coef_a1    = val;
            CFG_A2:           coef_a2    = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        i_cfg_data  <= CFG_DATA_W'($urandom);
    endtask

    task automatic load_setting(logic [15:0] d1, logic [15:0] d2, logic [15:0] g,
                                logic [15:0] b0, logic [15:0] b1, logic [15:0] b2,
                                logic [15:0] a1, logic [15:0] a2);
        write_reg(CFG_FIRST_DELAY, d1);
        write_reg(CFG_SECOND_DELAY, d2);
        write_reg(CFG_GAIN, g);
        write_reg(CFG_B0, b0);
        write_reg(CFG_B1, b1);
        write_reg(CFG_B2, b2);
        write_reg(CFG_A1, a1);
        write_reg(CFG_A2, a2);
    endtask

    // Picks a fresh setting. The gentle one keeps the echo audible and the
    // filter roughly stable, with delays of at most 1500; the wild one draws
    // every register at random and the extreme one takes the ends of every range.
    task automatic retune(t_tune style);
        logic [15:0] v [8];
        logic [15:0] edges [5];
        edges = '{16'h0000, 16'h0001, 16'h7fff, 16'h8000, 16'hffff};
        for (int r = 0; r < 8; r++) begin
            case (style)
                TUNE_WILD:    v[r] = 16'($urandom);
                TUNE_EXTREME: v[r] = edges[$urandom_range(4)];
                default: begin
                    if (r < 2) begin
                        v[r] = $urandom_range(1) ? 16'($urandom_range(300))
                                                 : 16'($urandom_range(1500));
                    end else if (r == 2) begin
                        v[r] = 16'($urandom_range(30000));
                    end else if (r == 3) begin
                        v[r] = 16'($urandom_range(16384, 6000));
                    end else begin
                        v[r] = 16'($urandom_range(4000) - 2000);
                    end
                end
            endcase
        end
        load_setting(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7]);
    endtask

    task automatic queue_samples(int count);
        logic signed [SAMPLE_W-1:0] s;
        for (int n = 0; n < count; n++) begin
            case ($urandom_range(9))
                5, 6, 7: s = SAMPLE_W'($urandom_range(4000) - 2000);
                8:       s = $urandom_range(1) ? SAMPLE_W'(16'h7fff - $urandom_range(3))
                                               : SAMPLE_W'(16'h8000 + $urandom_range(3));
                9:       s = '0;
                default: s = SAMPLE_W'($urandom);
            endcase
            pending_samples.push_back(s);
        end
    endtask

    // Waits until every queued sample has been taken and every result has come.
    task automatic settle();
        while (pending_samples.size() != 0 || in_busy || tap_pairs_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    initial begin : sequencer
        int sender_plan [6];
        int sink_plan [6];
        t_tune style_plan [6];
        sender_plan = '{20, 0, 35, 10, 50, 0};
        sink_plan   = '{15, 0, 45, 30, 50, 0};
        style_plan  = '{TUNE_GENTLE, TUNE_GENTLE, TUNE_WILD, TUNE_EXTREME, TUNE_GENTLE,
                        TUNE_GENTLE};

        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_sample    = '0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        in_busy     = 1'b0;
        sender_gap  = 0;
        sink_gap    = 0;
        sender_odds = 25;
        sink_odds   = 25;
        quiet_cycles = 0;
        fault_count  = 0;

        // Predictor in its reset state: cleared line, default settings.
        foreach (echo_line[k]) begin
            echo_line[k] = '0;
        end
        line_pos   = '0;
        mix_hist   = '{default: '0};
        wet_hist   = '{default: '0};
        tap1_delay = 1;
        tap2_delay = 1;
        fb_gain    = '0;
        coef_b0    = 16384;
        coef_b1    = '0;
        coef_b2    = '0;
        coef_a1    = '0;
        coef_a2    = '0;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. First a zero first-tap delay, which reads the word
        // about to be overwritten, with a gain just under twice unity and coefficients
        // at their limits so that the sum, the filter and the line write all
        // saturate.
        load_setting(16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000, 16'h7fff,
                     16'h7fff, 16'h8000);
        pending_samples = '{16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh0001,
                            16'shffff, 16'sh0000, 16'sh5555, 16'shaaaa, 16'sh7fff};
        settle();

        // Plain unity filter and unity feedback; the longest first-tap delay and
        // a zero delay on the fed-back tap.
        load_setting(16'h7fff, 16'h0000, 16'h8000, 16'h4000, 16'h0000, 16'h0000,
                     16'h0000, 16'h0000);
        pending_samples = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000,
                            16'sh8000, 16'sh3039, 16'shffff};
        settle();

        // No feedback at all, a negative full-scale b0 and extreme poles.
        load_setting(16'h0001, 16'h0002, 16'h0000, 16'h8000, 16'h0001, 16'hffff,
                     16'h8000, 16'h7fff);
        pending_samples = '{16'sh0064, 16'shff9c, 16'sh7fff, 16'sh8000, 16'sh0000,
                            16'sh0007};
        settle();

        // Random part: one setting per run, with the idling varied between runs
        // and switched off for the last one.
        for (int p = 0; p < 6; p++) begin
            sender_odds = sender_plan[p];
            sink_odds   = sink_plan[p];
            retune(style_plan[p]);
            if (p == 2) begin
                // The sender holds off mid-run until the block has drained.
                queue_samples(ITEMS_PER_RUN / 2);
                settle();
                queue_samples(ITEMS_PER_RUN - ITEMS_PER_RUN / 2);
            end else begin
                queue_samples(ITEMS_PER_RUN);
            end
            settle();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tap_pairs_due.size() != 0) begin
            $error("%0d results never arrived", tap_pairs_due.size());
            fault_count++;
        end
        if (fault_count == 0) begin
            $display("two_tap_feedback_echo verification clean");
        end else begin
            $display("two_tap_feedback_echo verification failed");
        end
        $finish;
    end

endmodule
